[rtl/core/pbo_pkg.sv]
package pbo_pkg;

  localparam int PHASE_BITS_DEF = 24;
  localparam int SINE_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam logic [63:0] HALF_PI_Q31 = 64'd3373259426;

  typedef enum logic [1:0] {
    OP_SINE   = 2'd0,
    OP_SAW    = 2'd1,
    OP_SQUARE = 2'd2,
    OP_TRI    = 2'd3
  } op_t;

  // Q31 sine by Taylor series, elaboration only
  function automatic longint sine_q31(input logic [63:0] x);
    logic [63:0] term;
    longint      sum;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x) >> 31) / 64'(2 * n);
      term = ((term * x) >> 31) / 64'(2 * n + 1);
      if ((n & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return sum;
  endfunction

endpackage

[rtl/core/pbo_sine_rom.sv]
module pbo_sine_rom
  import pbo_pkg::*;
#(
  parameter int DEPTH = SINE_DEPTH_DEF,
  parameter int FRAC  = SAMPLE_BITS_DEF - 2,
  localparam int AB   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AB-1:0] addr,
  output logic [FRAC:0] data
);

  logic [FRAC:0] tab [0:DEPTH];

  for (genvar k = 0; k <= DEPTH; k++) begin : g_tab
    localparam logic [63:0] X = (HALF_PI_Q31 * 64'(k) + 64'(DEPTH / 2)) / 64'(DEPTH);
    localparam longint S0 = sine_q31(X);
    localparam longint S1 = (S0 < 0) ? 64'sd0 : S0;
    localparam longint S2 = (S1 + (64'sd1 <<< (30 - FRAC))) >>> (31 - FRAC);
    localparam longint S3 = (S2 > (64'sd1 <<< FRAC)) ? (64'sd1 <<< FRAC) : S2;
    localparam logic [FRAC:0] V = S3[FRAC:0];
    assign tab[k] = V;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= tab[addr];
    end
  end

endmodule

[rtl/core/pbo_blep.sv]
module pbo_blep
  import pbo_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF,
  parameter int FRAC       = SAMPLE_BITS_DEF - 2
) (
  input  logic                   clk,
  input  logic [FRAC+2:1]        adv,
  input  logic [PHASE_BITS-1:0]  t,
  input  logic [PHASE_BITS-1:0]  dt,
  output logic signed [FRAC+1:0] blep
);

  localparam int PB = PHASE_BITS;
  localparam int NQ = FRAC + 1;

  logic [PB-1:0]   rem    [1:NQ];
  logic [PB-1:0]   dvs    [1:NQ];
  logic [FRAC-1:0] quo    [1:NQ];
  logic            act    [1:NQ];
  logic            neg    [1:NQ];

  // stage 1: pick the side of the jump
  logic [PB:0]   sum;
  logic          before_jump;
  logic          after_jump;

  assign sum         = {1'b0, t} + {1'b0, dt};
  assign before_jump = t < dt;
  assign after_jump  = sum[PB] && (sum[PB-1:0] != '0);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      rem[1] <= before_jump ? t : (~t + PB'(1));
      dvs[1] <= dt;
      quo[1] <= '0;
      act[1] <= before_jump || after_jump;
      neg[1] <= before_jump;
    end
  end

  // one quotient bit per stage
  for (genvar k = 2; k <= NQ; k++) begin : g_div
    logic [PB:0] r2;
    logic        ge;
    logic [PB:0] diff;

    assign r2   = {rem[k-1], 1'b0};
    assign ge   = r2 >= {1'b0, dvs[k-1]};
    assign diff = r2 - {1'b0, dvs[k-1]};

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        rem[k] <= ge ? diff[PB-1:0] : r2[PB-1:0];
        dvs[k] <= dvs[k-1];
        quo[k] <= {quo[k-1][FRAC-2:0], ge};
        act[k] <= act[k-1];
        neg[k] <= neg[k-1];
      end
    end
  end

  // (1 - q)^2
  logic [FRAC:0]     d;
  logic [2*FRAC+1:0] prod;
  logic signed [FRAC+1:0] mag;

  assign d    = {1'b1, {FRAC{1'b0}}} - {1'b0, quo[NQ]};
  assign prod = d * d;
  assign mag  = $signed({1'b0, prod[2*FRAC:FRAC]});

  always_ff @(posedge clk) begin
    if (adv[FRAC+2]) begin
      if (!act[NQ]) begin
        blep <= '0;
      end else if (neg[NQ]) begin
        blep <= -mag;
      end else begin
        blep <= mag;
      end
    end
  end

endmodule

[rtl/core/polyblep_waveform_oscillator_core.sv]
// PolyBLEP oscillator core: one sample per input beat, no internal state.
// Input stream (s_*): tdata carries the waveform select (0 sine, 1 sawtooth,
// 2 square, 3 triangle), the phase and the phase step, each phase a fraction
// of a cycle with 2^PHASE_BITS as one full cycle.
// Output stream (m_*): tdata carries one signed Q2.(SAMPLE_BITS-2) sample,
// saturated to SAMPLE_BITS.
// A new beat is taken every cycle while the output stream is not stalled;
// the pipeline depth is set by the restoring divider of the PolyBLEP ratio,
// one quotient bit per stage, followed by the squaring multiplier and the
// final add and clamp. The sine comes from a registered quarter-wave ROM
// of SINE_TABLE_DEPTH+1 words. A zero phase step turns the correction off.
// Each stage has its own valid bit; when m_tready is low, the stages holding
// data freeze while empty stages further up keep filling, so s_tready stays
// high until the pipeline is full. Reset clears all valid bits only.
module polyblep_waveform_oscillator_core
  import pbo_pkg::*;
#(
  parameter int PHASE_BITS       = PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
  parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF,
  localparam int IN_W  = ((2 + 2 * PHASE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // opcode, phase, phase_step
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // sample
);

  localparam int PB = PHASE_BITS;
  localparam int D  = SINE_TABLE_DEPTH;
  localparam int F  = SAMPLE_BITS - 2;
  localparam int K  = F + 3;
  localparam int W  = F + 4;
  localparam int IB = $clog2(4 * D);
  localparam int AB = $clog2(D + 1);

  localparam logic [IB:0]          FOUR_D = (IB + 1)'(4 * D);
  localparam logic signed [W-1:0]  ONE_W  = W'(1 << F);
  localparam logic signed [W-1:0]  THREE_W = W'(3 << F);
  localparam logic signed [W-1:0]  SAT_HI = W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [W-1:0]  SAT_LO = -W'(1 << (SAMPLE_BITS - 1));

  logic [K:1]   v;
  logic [K+1:1] adv;

  always_comb begin
    adv[K+1] = m_tready;
    for (int k = K; k >= 1; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign s_tready = adv[1];
  assign m_tvalid = v[K];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) begin
        v[1] <= s_tvalid;
      end
      for (int k = 2; k <= K; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  op_t          in_op;
  logic [PB-1:0] in_ph;
  logic [PB-1:0] in_dt;

  assign in_op = op_t'(s_tdata[1:0]);
  assign in_ph = s_tdata[PB+1:2];
  assign in_dt = s_tdata[2*PB+1:PB+2];

  // stage 1: naive waveforms and sine index
  logic [PB+F+1:0]        wide;
  logic signed [W-1:0]    saw_n;
  logic signed [W-1:0]    four_n;
  logic signed [W-1:0]    naive_next;
  logic [PB+IB:0]         sprod;

  assign wide   = {in_ph, {(F + 2){1'b0}}};
  assign saw_n  = $signed({3'b000, wide[PB+F+1:PB+1]});
  assign four_n = $signed({2'b00, wide[PB+F+1:PB]});
  assign sprod  = in_ph * FOUR_D;

  always_comb begin
    case (in_op)
      OP_SAW:    naive_next = saw_n - ONE_W;
      OP_SQUARE: naive_next = in_ph[PB-1] ? -ONE_W : ONE_W;
      OP_TRI:    naive_next = in_ph[PB-1] ? (THREE_W - four_n) : (four_n - ONE_W);
      default:   naive_next = '0;
    endcase
  end

  op_t                 op_d    [1:K-1];
  logic signed [W-1:0] naive_d [1:3];
  logic signed [W-1:0] base_d  [4:K-1];
  logic [IB-1:0]       sidx;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      op_d[1]    <= in_op;
      naive_d[1] <= naive_next;
      sidx       <= sprod[PB+IB-1:PB];
    end
  end

  for (genvar k = 2; k <= K - 1; k++) begin : g_op
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        op_d[k] <= op_d[k-1];
      end
    end
  end

  // stage 2: quadrant fold
  logic [1:0]    squad;
  logic [IB-1:0] sj;
  logic [AB-1:0] saddr;
  logic [AB-1:0] saddr_next;
  logic          sneg2;
  logic          sneg3;

  always_comb begin
    if (sidx >= IB'(3 * D)) begin
      squad = 2'd3;
      sj    = sidx - IB'(3 * D);
    end else if (sidx >= IB'(2 * D)) begin
      squad = 2'd2;
      sj    = sidx - IB'(2 * D);
    end else if (sidx >= IB'(D)) begin
      squad = 2'd1;
      sj    = sidx - IB'(D);
    end else begin
      squad = 2'd0;
      sj    = sidx;
    end
    saddr_next = squad[0] ? (AB'(D) - AB'(sj)) : AB'(sj);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      naive_d[2] <= naive_d[1];
      saddr      <= saddr_next;
      sneg2      <= squad[1];
    end
    if (adv[3]) begin
      naive_d[3] <= naive_d[2];
      sneg3      <= sneg2;
    end
  end

  // stage 3: ROM read
  logic [F:0] rom_q;

  pbo_sine_rom #(
    .DEPTH (D),
    .FRAC  (F)
  ) u_rom (
    .clk  (clk),
    .en   (adv[3]),
    .addr (saddr),
    .data (rom_q)
  );

  // stage 4: base value
  logic signed [W-1:0] sine_v;

  assign sine_v = $signed({3'b000, rom_q});

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      if (op_d[3] == OP_SINE) begin
        base_d[4] <= sneg3 ? -sine_v : sine_v;
      end else begin
        base_d[4] <= naive_d[3];
      end
    end
  end

  for (genvar k = 5; k <= K - 1; k++) begin : g_base
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        base_d[k] <= base_d[k-1];
      end
    end
  end

  // correction lanes: at the phase and half a cycle on
  logic [PB-1:0]        t_half;
  logic signed [F+1:0]  blep_a;
  logic signed [F+1:0]  blep_b;

  assign t_half = {~in_ph[PB-1], in_ph[PB-2:0]};

  pbo_blep #(
    .PHASE_BITS (PB),
    .FRAC       (F)
  ) u_blep_a (
    .clk  (clk),
    .adv  (adv[F+2:1]),
    .t    (in_ph),
    .dt   (in_dt),
    .blep (blep_a)
  );

  pbo_blep #(
    .PHASE_BITS (PB),
    .FRAC       (F)
  ) u_blep_b (
    .clk  (clk),
    .adv  (adv[F+2:1]),
    .t    (t_half),
    .dt   (in_dt),
    .blep (blep_b)
  );

  // last stage: combine and clamp
  logic signed [W-1:0]           ea;
  logic signed [W-1:0]           eb;
  logic signed [W-1:0]           y;
  logic signed [SAMPLE_BITS-1:0] sample_next;
  logic [SAMPLE_BITS-1:0]        sample;

  assign ea = {{2{blep_a[F+1]}}, blep_a};
  assign eb = {{2{blep_b[F+1]}}, blep_b};

  always_comb begin
    case (op_d[K-1])
      OP_SAW:    y = base_d[K-1] - ea;
      OP_SQUARE: y = base_d[K-1] + ea - eb;
      default:   y = base_d[K-1];
    endcase
    if (y > SAT_HI) begin
      sample_next = SAT_HI[SAMPLE_BITS-1:0];
    end else if (y < SAT_LO) begin
      sample_next = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sample_next = y[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[K]) begin
      sample <= sample_next;
    end
  end

  assign m_tdata = OUT_W'(sample);

endmodule
